@@ design/dks_pkg.sv @@
package dks_pkg;

  localparam int KEY_BITS    = 64;
  localparam int HALF_BITS   = 28;
  localparam int CD_BITS     = 56;
  localparam int SUBKEY_BITS = 48;
  localparam int ROUNDS      = 16;
  localparam int ROUND_BITS  = 4;

  typedef logic [CD_BITS-1:0]     cd_t;
  typedef logic [HALF_BITS-1:0]   half_t;
  typedef logic [SUBKEY_BITS-1:0] subkey_t;

  // per-cell control from the chain arbiter
  typedef struct packed {
    logic load;        // take neighbor's C:D this cycle
    logic take;        // subkey leaves to the output register
    logic two_places;  // rotate amount of this round: 1 or 2
  } cell_ctrl_t;

  // PC-1: entry i is the key bit (1 = msb) that lands in C:D bit i (1 = msb)
  localparam logic [6:0] PC1_TABLE [CD_BITS] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  // PC-2: entry i is the C:D bit (1 = msb) that lands in subkey bit i (1 = msb)
  localparam logic [5:0] PC2_TABLE [SUBKEY_BITS] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // rounds whose halves rotate by two places
  localparam logic [ROUNDS-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

  function automatic cd_t pc1(input logic [KEY_BITS-1:0] key);
    cd_t cd;
    int  src;
    for (int i = 0; i < CD_BITS; i++) begin
      src = KEY_BITS - int'(PC1_TABLE[i]);
      cd[CD_BITS-1-i] = key[src];
    end
    return cd;
  endfunction

  function automatic subkey_t pc2(input cd_t cd);
    subkey_t sk;
    int      src;
    for (int i = 0; i < SUBKEY_BITS; i++) begin
      src = CD_BITS - int'(PC2_TABLE[i]);
      sk[SUBKEY_BITS-1-i] = cd[src];
    end
    return sk;
  endfunction

  function automatic half_t rotl28(input half_t v, input logic two);
    half_t r;
    if (two) begin
      r = {v[HALF_BITS-3:0], v[HALF_BITS-1:HALF_BITS-2]};
    end else begin
      r = {v[HALF_BITS-2:0], v[HALF_BITS-1]};
    end
    return r;
  endfunction

  function automatic cd_t rotate_cd(input cd_t cd, input logic two);
    return {rotl28(cd[CD_BITS-1:HALF_BITS], two), rotl28(cd[HALF_BITS-1:0], two)};
  endfunction

endpackage

@@ design/des_key_schedule.sv @@
// DES key schedule. Each 64-bit key word on the slave stream (key bit 1 in
// s_tdata[63], parity bits ignored) yields sixteen subkey words on the master
// stream, rounds 0 to 15 in order, with tlast on round 15. Inside is a row of
// sixteen round cells: the key enters cell 0 after PC-1 with its first
// rotation applied, and each time a cell's subkey is taken its C:D moves on to
// the next cell, which applies that round's rotation. Only the most advanced
// key in the row may emit, so order is kept across keys. The next key is taken
// as soon as cell 0 is free, i.e. in the cycle after the first subkey of the
// previous key has left, so keys overlap; the single output port (one subkey
// per cycle while the master side is ready) sets the pace of the row. The
// output word sits in a register, so a stalled master side does not stop the
// slave side until cell 0 fills. No clearing pass; reset empties the row.
module des_key_schedule (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] key
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [47:0] subkey, [51:48] round_index, rest zero
  output logic        m_tlast
);

  localparam int ROUNDS     = dks_pkg::ROUNDS;
  localparam int ROUND_BITS = dks_pkg::ROUND_BITS;

  logic [ROUNDS-1:0]    valid;
  dks_pkg::cd_t         cd     [ROUNDS];
  dks_pkg::subkey_t     subkey [ROUNDS];
  dks_pkg::cell_ctrl_t  ctrl   [ROUNDS];
  dks_pkg::cd_t         in_cd  [ROUNDS];
  logic [ROUNDS-1:0]    grant;

  logic [ROUND_BITS-1:0] sel;
  logic                  any_valid;
  logic                  out_free;
  logic                  emit;

  // most advanced occupied cell owns the output
  always_comb begin
    sel = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      if (valid[r]) begin
        sel = ROUND_BITS'(r);
      end
    end
  end

  assign any_valid = |valid;
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = any_valid && out_free;
  assign s_tready  = !valid[0];

  for (genvar r = 0; r < ROUNDS; r++) begin : g_cell
    assign grant[r] = emit && (sel == ROUND_BITS'(r));

    if (r == 0) begin : g_head
      assign in_cd[r]     = dks_pkg::pc1(s_tdata);
      assign ctrl[r].load = s_tvalid && s_tready;
    end else begin : g_body
      assign in_cd[r]     = cd[r-1];
      assign ctrl[r].load = grant[r-1];
    end
    assign ctrl[r].take       = grant[r];
    assign ctrl[r].two_places = dks_pkg::ROT_TWO[r];

    dks_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl[r]),
      .in_cd  (in_cd[r]),
      .valid  (valid[r]),
      .cd     (cd[r]),
      .subkey (subkey[r])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= any_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {4'b0, sel, subkey[sel]};
      m_tlast <= (sel == ROUND_BITS'(ROUNDS - 1));
    end
  end

endmodule

@@ design/dks_cell.sv @@
// One round of the schedule: holds rotated C:D and shows its subkey.
module dks_cell (
  input  logic               clk,
  input  logic               rst,
  input  dks_pkg::cell_ctrl_t ctrl,
  input  dks_pkg::cd_t       in_cd,
  output logic               valid,
  output dks_pkg::cd_t       cd,
  output dks_pkg::subkey_t   subkey
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end else if (ctrl.take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cd <= dks_pkg::rotate_cd(in_cd, ctrl.two_places);
    end
  end

  assign subkey = dks_pkg::pc2(cd);

endmodule
